@@ design/fpcu_pkg.sv @@
// Shared constants, command/status types and the saturation helper of the calculator.
`timescale 1ns / 1ps
package fpcu_pkg;

  // Intermediate widths
  localparam int unsigned NumW  = 48;
  localparam int unsigned RemW  = 33;

  // Register reset values
  localparam logic [7:0]  IterLimitRst = 8'd100;
  localparam logic [15:0] TolRst       = 16'd7;

  // Configuration register indexes
  localparam logic CFG_ITER_LIMIT = 1'b0;
  localparam logic CFG_TOL        = 1'b1;

  // Opcodes
  localparam logic [2:0] OP_DIV  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_POW  = 3'd3;
  localparam logic [2:0] OP_SQRT = 3'd4;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DIV0    = 3'd1;
  localparam logic [2:0] ST_SAT     = 3'd2;
  localparam logic [2:0] ST_NEGROOT = 3'd3;
  localparam logic [2:0] ST_BADOP   = 3'd4;

  // Q16.16 constants
  localparam logic [31:0] Q16_ONE = 32'h0001_0000;
  localparam logic [31:0] Q16_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q16_MIN = 32'h8000_0000;

  // Datapath micro-operations
  localparam logic [3:0] UOP_NOP      = 4'd0;
  localparam logic [3:0] UOP_LOAD     = 4'd1;
  localparam logic [3:0] UOP_DIV_INIT = 4'd2;
  localparam logic [3:0] UOP_DIV_STEP = 4'd3;
  localparam logic [3:0] UOP_DIV_END  = 4'd4;
  localparam logic [3:0] UOP_MUL      = 4'd5;
  localparam logic [3:0] UOP_MUL_END  = 4'd6;
  localparam logic [3:0] UOP_PMUL     = 4'd7;
  localparam logic [3:0] UOP_POW_UPD  = 4'd8;
  localparam logic [3:0] UOP_POW_END  = 4'd9;
  localparam logic [3:0] UOP_SQ_UPD   = 4'd10;
  localparam logic [3:0] UOP_SQ_END   = 4'd11;

  typedef struct packed {
    logic [3:0] uop;
    logic       out_load;
  } fpcu_cmd_t;

  typedef struct packed {
    logic early;
    logic div_last;
    logic pow_end;
    logic pow_ovf;
    logic sq_end;
  } fpcu_sts_t;

  // Apply sign to a magnitude and clamp to 32 bits; bit 32 flags saturation
  function automatic logic [32:0] sat_q16(input logic [NumW-1:0] mag, input logic neg);
    logic [32:0] res;
    if (neg) begin
      if (mag > {16'd0, Q16_MIN}) res = {1'b1, Q16_MIN};
      else                        res = {1'b0, (~mag[31:0]) + 32'd1};
    end else begin
      if (mag > {16'd0, Q16_MAX}) res = {1'b1, Q16_MAX};
      else                        res = {1'b0, mag[31:0]};
    end
    return res;
  endfunction

endpackage

@@ design/fpcu_dp.sv @@
// Datapath: operand registers, shared restoring divider, multiplier and result registers.
`timescale 1ns / 1ps
module fpcu_dp
  import fpcu_pkg::*;
(
  input  logic               clk,
  input  fpcu_cmd_t          cmd,
  output fpcu_sts_t          sts,
  input  logic [2:0]         in_opcode,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  input  logic [7:0]         sqrt_limit,
  input  logic [15:0]        sqrt_tol,
  output logic signed [31:0] out_result_value,
  output logic [2:0]         out_status_code
);

  logic [2:0]      op_r;
  logic [31:0]     a_r, b_r, x_r;
  logic [15:0]     iter_r;
  logic            n_odd_r, conv_r, early_r;
  logic [NumW-1:0] dq_r;
  logic [RemW-1:0] drem_r;
  logic [31:0]     dden_r;
  logic [5:0]      dcnt_r;
  logic [63:0]     prod_r;
  logic            pneg_r;
  logic [31:0]     res_r;
  logic [2:0]      stat_r;
  logic [31:0]     out_res_r;
  logic [2:0]      out_st_r;

  logic [31:0]     abs_a, abs_b, abs_x;
  logic [32:0]     pow_sum;
  logic [15:0]     pow_n;
  logic [RemW-1:0] trial;
  logic            trial_ge;
  logic [32:0]     div_sat, prod_sat, root_sat;
  logic [48:0]     sq_sum;
  logic [47:0]     sq_half;
  logic [31:0]     xn, diff;
  logic [47:0]     tol_x;
  logic            conv;

  // Operand magnitudes
  assign abs_a = a_r[31] ? (~a_r + 32'd1) : a_r;
  assign abs_b = b_r[31] ? (~b_r + 32'd1) : b_r;
  assign abs_x = x_r[31] ? (~x_r + 32'd1) : x_r;

  // Power count: ceil(b / 1.0)
  assign pow_sum = {1'b0, in_operand_b} + 33'h0_0000_FFFF;
  assign pow_n   = pow_sum[31:16];

  // One restoring division step
  assign trial    = {drem_r[31:0], dq_r[NumW-1]};
  assign trial_ge = trial >= {1'b0, dden_r};

  assign div_sat  = sat_q16(dq_r, a_r[31] ^ b_r[31]);
  assign prod_sat = sat_q16(prod_r[63:16], pneg_r);
  assign root_sat = sat_q16({16'd0, x_r}, 1'b0);

  // Newton update and convergence test
  assign sq_sum  = {1'b0, dq_r} + {17'd0, x_r};
  assign sq_half = sq_sum[48:1];
  always_comb begin
    if (sq_half > 48'h0000_FFFF_FFFF) xn = 32'hFFFF_FFFF;
    else if (sq_half == 48'd0)        xn = 32'd1;
    else                              xn = sq_half[31:0];
  end
  assign diff  = (xn > x_r) ? (xn - x_r) : (x_r - xn);
  assign tol_x = 48'(sqrt_tol) * 48'(xn);
  assign conv  = {diff, 16'd0} < tol_x;

  // Status towards the controller
  assign sts.early    = early_r;
  assign sts.div_last = dcnt_r == 6'(NumW - 1);
  assign sts.pow_end  = (iter_r == 16'd0) || (x_r == 32'd0);
  assign sts.pow_ovf  = prod_sat[32];
  assign sts.sq_end   = (iter_r == 16'd0) || conv_r;

  // Execute the micro-operation
  always_ff @(posedge clk) begin
    case (cmd.uop)
      UOP_LOAD: begin
        op_r    <= in_opcode;
        a_r     <= in_operand_a;
        b_r     <= in_operand_b;
        conv_r  <= 1'b0;
        n_odd_r <= pow_n[0];
        case (in_opcode)
          OP_DIV: begin
            early_r <= in_operand_b == 32'sd0;
            res_r   <= 32'd0;
            stat_r  <= ST_DIV0;
          end
          OP_MUL: begin
            early_r <= 1'b0;
            res_r   <= 32'd0;
            stat_r  <= ST_OK;
          end
          OP_POW: begin
            x_r     <= Q16_ONE;
            iter_r  <= pow_n;
            early_r <= in_operand_b[31] || (in_operand_b == 32'sd0);
            res_r   <= Q16_ONE;
            stat_r  <= ST_OK;
          end
          OP_SQRT: begin
            x_r    <= in_operand_a;
            iter_r <= {8'd0, sqrt_limit};
            if (in_operand_a[31]) begin
              early_r <= 1'b1;
              res_r   <= 32'd0;
              stat_r  <= ST_NEGROOT;
            end else if (in_operand_a == 32'sd0) begin
              early_r <= 1'b1;
              res_r   <= 32'd0;
              stat_r  <= ST_OK;
            end else begin
              early_r <= sqrt_limit == 8'd0;
              res_r   <= in_operand_a;
              stat_r  <= ST_OK;
            end
          end
          default: begin
            early_r <= 1'b1;
            res_r   <= 32'd0;
            stat_r  <= ST_BADOP;
          end
        endcase
      end
      UOP_DIV_INIT: begin
        dq_r   <= {abs_a, 16'd0};
        dden_r <= (op_r == OP_SQRT) ? x_r : abs_b;
        drem_r <= '0;
        dcnt_r <= '0;
      end
      UOP_DIV_STEP: begin
        drem_r <= trial_ge ? (trial - {1'b0, dden_r}) : trial;
        dq_r   <= {dq_r[NumW-2:0], trial_ge};
        dcnt_r <= dcnt_r + 6'd1;
      end
      UOP_DIV_END: begin
        res_r  <= div_sat[31:0];
        stat_r <= div_sat[32] ? ST_SAT : ST_OK;
      end
      UOP_MUL: begin
        prod_r <= 64'(abs_a) * 64'(abs_b);
        pneg_r <= a_r[31] ^ b_r[31];
      end
      UOP_PMUL: begin
        prod_r <= 64'(abs_x) * 64'(abs_a);
        pneg_r <= x_r[31] ^ a_r[31];
      end
      UOP_MUL_END: begin
        res_r  <= prod_sat[31:0];
        stat_r <= prod_sat[32] ? ST_SAT : ST_OK;
      end
      UOP_POW_UPD: begin
        if (prod_sat[32]) begin
          res_r  <= (a_r[31] && n_odd_r) ? Q16_MIN : Q16_MAX;
          stat_r <= ST_SAT;
        end else begin
          x_r    <= prod_sat[31:0];
          iter_r <= iter_r - 16'd1;
        end
      end
      UOP_POW_END: begin
        res_r  <= x_r;
        stat_r <= ST_OK;
      end
      UOP_SQ_UPD: begin
        x_r    <= xn;
        iter_r <= iter_r - 16'd1;
        conv_r <= conv;
      end
      UOP_SQ_END: begin
        res_r  <= root_sat[31:0];
        stat_r <= root_sat[32] ? ST_SAT : ST_OK;
      end
      default: begin
      end
    endcase
  end

  // Hold the finished transaction in the output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_res_r <= res_r;
      out_st_r  <= stat_r;
    end
  end

  assign out_result_value = out_res_r;
  assign out_status_code  = out_st_r;

endmodule

@@ design/fpcu_ctrl.sv @@
// Controller: sequences the datapath through each operation and owns the handshakes.
`timescale 1ns / 1ps
module fpcu_ctrl
  import fpcu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_opcode,
  output logic       out_valid,
  input  logic       out_stall,
  input  fpcu_sts_t  sts,
  output fpcu_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_DV_RUN  = 4'd2;
  localparam logic [3:0] S_DV_END  = 4'd3;
  localparam logic [3:0] S_MUL_END = 4'd4;
  localparam logic [3:0] S_POW_CHK = 4'd5;
  localparam logic [3:0] S_POW_UPD = 4'd6;
  localparam logic [3:0] S_SQ_CHK  = 4'd7;
  localparam logic [3:0] S_SQ_RUN  = 4'd8;
  localparam logic [3:0] S_SQ_UPD  = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [2:0] op_r;
  logic       out_valid_r, out_valid_nxt;
  logic       in_acc, slot_free;

  assign in_stall  = state_r != S_IDLE;
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // Next state and micro-operation
  always_comb begin
    state_nxt    = state_r;
    cmd.uop      = UOP_NOP;
    cmd.out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.uop   = UOP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.early) begin
          state_nxt = S_FIN;
        end else begin
          case (op_r)
            OP_DIV: begin
              cmd.uop   = UOP_DIV_INIT;
              state_nxt = S_DV_RUN;
            end
            OP_MUL: begin
              cmd.uop   = UOP_MUL;
              state_nxt = S_MUL_END;
            end
            OP_POW:  state_nxt = S_POW_CHK;
            OP_SQRT: state_nxt = S_SQ_CHK;
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_DV_RUN: begin
        cmd.uop = UOP_DIV_STEP;
        if (sts.div_last) state_nxt = S_DV_END;
      end
      S_DV_END: begin
        cmd.uop   = UOP_DIV_END;
        state_nxt = S_FIN;
      end
      S_MUL_END: begin
        cmd.uop   = UOP_MUL_END;
        state_nxt = S_FIN;
      end
      S_POW_CHK: begin
        if (sts.pow_end) begin
          cmd.uop   = UOP_POW_END;
          state_nxt = S_FIN;
        end else begin
          cmd.uop   = UOP_PMUL;
          state_nxt = S_POW_UPD;
        end
      end
      S_POW_UPD: begin
        cmd.uop   = UOP_POW_UPD;
        state_nxt = sts.pow_ovf ? S_FIN : S_POW_CHK;
      end
      S_SQ_CHK: begin
        if (sts.sq_end) begin
          cmd.uop   = UOP_SQ_END;
          state_nxt = S_FIN;
        end else begin
          cmd.uop   = UOP_DIV_INIT;
          state_nxt = S_SQ_RUN;
        end
      end
      S_SQ_RUN: begin
        cmd.uop = UOP_DIV_STEP;
        if (sts.div_last) state_nxt = S_SQ_UPD;
      end
      S_SQ_UPD: begin
        cmd.uop   = UOP_SQ_UPD;
        state_nxt = S_SQ_CHK;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid: set on load, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load)              out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the opcode of the accepted transaction
  always_ff @(posedge clk) begin
    if (in_acc) op_r <= in_opcode;
  end

  assign out_valid = out_valid_r;

endmodule

@@ design/fixed_point_calculator_unit.sv @@
// Top level of the fixed-point calculator: configuration registers, controller and datapath.
`timescale 1ns / 1ps
// Usage:
//   Input channel: in_valid/in_stall with in_opcode, in_operand_a, in_operand_b
//   (signed Q16.16). One transaction is taken when in_valid is high and in_stall low.
//   Result channel: out_valid/out_stall with out_result_value (signed Q16.16) and
//   out_status_code. One result per input transaction, in order.
//   Configuration: cfg_wr_en/cfg_index/cfg_wdata; index 0 sets the Newton iteration
//   limit, index 1 the relative tolerance (Q0.16). Write only while idle.
// Sequencing, through the single 48-step restoring divider and the shared multiplier:
//   bad opcode, divide by zero and trivial cases finish without either of them
//   multiply takes one product; divide takes one full divider run
//   power: n multiplications (n = ceil(b)), ending early when a product saturates
//   square root: k Newton steps (k <= iteration limit), each one full divider run
// One transaction is worked on at a time; the next is taken once the result has
// moved to the output register, even while that result still waits.
// Reset (synchronous, rst_n low) empties the block and restores limit 100 and
// tolerance 7. While out_stall is high the result holds and the block stops
// after finishing at most one further transaction.
module fixed_point_calculator_unit
  import fpcu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_opcode,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result_value,
  output logic [2:0]         out_status_code,
  input  logic               cfg_wr_en,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  logic [7:0]  iter_limit_r;
  logic [15:0] tol_r;
  fpcu_cmd_t   cmd;
  fpcu_sts_t   sts;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_limit_r <= IterLimitRst;
      tol_r        <= TolRst;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_ITER_LIMIT) iter_limit_r <= cfg_wdata[7:0];
      if (cfg_index == CFG_TOL)        tol_r        <= cfg_wdata;
    end
  end

  fpcu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpcu_dp u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_opcode),
    .in_operand_a     (in_operand_a),
    .in_operand_b     (in_operand_b),
    .sqrt_limit       (iter_limit_r),
    .sqrt_tol         (tol_r),
    .out_result_value (out_result_value),
    .out_status_code  (out_status_code)
  );

endmodule

@@ design/fpcu_chk.sv @@
// Port-level checker for the fixed-point calculator, bound to the top level.
`timescale 1ns / 1ps
module fpcu_chk
  import fpcu_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_result_value,
  input logic [2:0]         out_status_code
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Only defined status codes leave the block
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status_code <= ST_BADOP))
    else $error("undefined status code");

  // Error transactions carry a zero result
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status_code == ST_DIV0 || out_status_code == ST_NEGROOT ||
                  out_status_code == ST_BADOP) |-> out_result_value == 32'sd0)
    else $error("error result not zero");

  // An accepted transaction makes the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after acceptance");

endmodule

bind fixed_point_calculator_unit fpcu_chk u_fpcu_chk (.*);

@@ sim/tb_fixed_point_calculator_unit.sv @@
// Self-checking testbench of the fixed-point calculator with random stalls and phases.
`timescale 1ns / 1ps
module tb_fixed_point_calculator_unit;
  import fpcu_pkg::*;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } calc_req_t;

  typedef struct {
    logic signed [31:0] value;
    logic [2:0]         status;
  } calc_res_t;

  localparam int unsigned IdleLimit = 300000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_opcode = '0;
  logic signed [31:0] in_operand_a = '0;
  logic signed [31:0] in_operand_b = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_result_value;
  logic [2:0]         out_status_code;
  logic               cfg_wr_en = 1'b0;
  logic [0:0]         cfg_index = '0;
  logic [15:0]        cfg_wdata = '0;

  // Model copy of the configuration registers
  logic [7:0]  iter_limit = IterLimitRst;
  logic [15:0] tolerance  = TolRst;

  calc_req_t   pending_reqs[$];
  calc_res_t   expected_results[$];
  int unsigned error_count = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  logic        in_burst = 1'b0;
  logic        out_burst = 1'b0;

  fixed_point_calculator_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_value(out_result_value), .out_status_code(out_status_code),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clamp a wide value to 32 bits, flagging saturation
  function automatic calc_res_t clamp_q16(input longint v);
    calc_res_t r;
    r.status = ST_OK;
    if (v > 64'sd2147483647) begin
      r.value = Q16_MAX; r.status = ST_SAT;
    end else if (v < -64'sd2147483648) begin
      r.value = Q16_MIN; r.status = ST_SAT;
    end else begin
      r.value = v[31:0];
    end
    return r;
  endfunction

  function automatic calc_res_t power_q16(input longint a, input longint b);
    calc_res_t r;
    longint acc, prod, n, i;
    r.status = ST_OK;
    acc = 65536;
    if (b > 0) begin
      n = (b + 65535) >>> 16;
      for (i = 0; i < n && acc != 0; i++) begin
        prod = (acc * a) / 65536;
        if (prod > 64'sd2147483647 || prod < -64'sd2147483648) begin
          r.status = ST_SAT;
          r.value = (a < 0 && n[0]) ? Q16_MIN : Q16_MAX;
          return r;
        end
        acc = prod;
      end
    end
    r.value = acc[31:0];
    return r;
  endfunction

  // Newton root starting from the operand itself
  function automatic calc_res_t root_q16(input longint a);
    calc_res_t r;
    longint unsigned num, x, prev, diff;
    int i;
    r.value = '0;
    r.status = ST_OK;
    if (a < 0) begin
      r.status = ST_NEGROOT;
      return r;
    end
    if (a == 0) return r;
    num = longint'(a) << 16;
    x = a;
    for (i = 0; i < int'(iter_limit); i++) begin
      prev = x;
      x = (num / x + x) >> 1;
      if (x < 1) x = 1;
      if (x > 64'hFFFF_FFFF) x = 64'hFFFF_FFFF;
      diff = (x > prev) ? x - prev : prev - x;
      if (diff * 65536 < longint'(tolerance) * x) break;
    end
    return clamp_q16(longint'(x));
  endfunction

  function automatic calc_res_t calc_result(input calc_req_t q);
    calc_res_t r;
    longint a, b;
    a = q.a;
    b = q.b;
    r.value = '0;
    r.status = ST_OK;
    case (q.op)
      OP_DIV: begin
        if (b == 0) r.status = ST_DIV0;
        else        r = clamp_q16((a * 65536) / b);
      end
      OP_MUL:  r = clamp_q16((a * b) / 65536);
      OP_POW:  r = power_q16(a, b);
      OP_SQRT: r = root_q16(a);
      default: r.status = ST_BADOP;
    endcase
    return r;
  endfunction

  // Mostly short gaps, some long, with stretches of none
  function automatic int unsigned pick_gap(input logic burst);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (burst || sel < 60) return 0;
    if (sel < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [31:0] pick_operand();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4: v = $urandom_range(0, 4 * 65536);
      5: begin
        case ($urandom_range(0, 6))
          0: v = 0;
          1: v = Q16_MIN;
          2: v = Q16_MAX;
          3: v = Q16_ONE;
          4: v = -Q16_ONE;
          5: v = 1;
          default: v = -1;
        endcase
      end
      default: v = $urandom_range(0, 1 << 24);
    endcase
    if ($urandom_range(0, 2) == 0) v = -v;
    return v;
  endfunction

  function automatic calc_req_t pick_req();
    calc_req_t q;
    int unsigned sel;
    sel = $urandom_range(0, 19);
    q.op = (sel == 0) ? 3'($urandom_range(0, 7)) : 3'((sel % 4) + 1);
    q.a = pick_operand();
    q.b = pick_operand();
    if (q.op == OP_POW && $urandom_range(0, 9) != 0) begin
      q.b = $urandom_range(0, 12 * 65536);
      if ($urandom_range(0, 4) == 0) q.b = -q.b;
      if ($urandom_range(0, 5) == 0) q.a = ($urandom_range(0, 1) != 0) ? Q16_ONE : -Q16_ONE;
    end
    return q;
  endfunction

  task automatic add_req(input logic [2:0] op, input logic signed [31:0] a,
                         input logic signed [31:0] b);
    calc_req_t q;
    q.op = op; q.a = a; q.b = b;
    pending_reqs.push_back(q);
  endtask

  task automatic add_random(input int unsigned count);
    repeat (count) pending_reqs.push_back(pick_req());
  endtask

  // Hold until every transaction has left the block
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_ITER_LIMIT) iter_limit <= data[7:0];
    else                       tolerance  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h, want %h", what, got, want);
    error_count++;
  endtask

  // Driver: advance to the next pending transaction once the slot is free
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) expected_results.push_back(
          calc_result('{in_opcode, in_operand_a, in_operand_b}));
      if ($urandom_range(0, 63) == 0) in_burst <= ~in_burst;
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          calc_req_t q;
          q = pending_reqs.pop_front();
          in_opcode <= q.op;
          in_operand_a <= q.a;
          in_operand_b <= q.b;
          in_valid <= 1'b1;
          in_gap <= pick_gap(in_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_result_value, 32'd0);
        end else begin
          calc_res_t e;
          e = expected_results.pop_front();
          if (out_result_value !== e.value)
            report_mismatch("result_value", out_result_value, e.value);
          if (out_status_code !== e.status)
            report_mismatch("status_code", 32'(out_status_code), 32'(e.status));
        end
      end
      if ($urandom_range(0, 63) == 0) out_burst <= ~out_burst;
      if (out_gap != 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        out_gap <= pick_gap(out_burst);
      end
    end
  end

  // Watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("fixed_point_calculator_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners at reset settings
    add_req(OP_DIV, 32'sh0003_0000, 0);
    add_req(OP_DIV, Q16_MIN, -Q16_ONE);
    add_req(OP_DIV, Q16_MAX, 1);
    add_req(OP_DIV, -32'sh0007_0000, 32'sh0002_0000);
    add_req(OP_MUL, Q16_MAX, Q16_MAX);
    add_req(OP_MUL, Q16_MIN, Q16_MAX);
    add_req(OP_MUL, -32'sd3, 32'sh0000_8000);
    add_req(OP_POW, 32'sh0002_0000, 0);
    add_req(OP_POW, 32'sh0002_0000, -Q16_ONE);
    add_req(OP_POW, 32'sh0003_0000, 32'sh0000_8000);
    add_req(OP_POW, 32'sh0002_0000, 32'sh0028_0000);
    add_req(OP_POW, -32'sh0002_0000, 32'sh001F_0000);
    add_req(OP_POW, -Q16_ONE, 32'sh0003_0001);
    add_req(OP_POW, Q16_ONE, Q16_MAX);
    add_req(OP_POW, 32'sh0000_8000, 32'sh0014_0000);
    add_req(OP_SQRT, -32'sd1, 0);
    add_req(OP_SQRT, 0, 0);
    add_req(OP_SQRT, Q16_MAX, 0);
    add_req(OP_SQRT, 1, 0);
    add_req(OP_SQRT, 32'sh0002_0000, 0);
    add_req(3'd0, 1, 1);
    add_req(3'd5, 1, 1);
    add_req(3'd6, 1, 1);
    add_req(3'd7, Q16_MIN, Q16_MAX);
    add_random(150);
    wait_drained();

    // Single Newton step with the loosest tolerance
    write_reg(CFG_ITER_LIMIT, 16'd1);
    write_reg(CFG_TOL, 16'hFFFF);
    add_random(100);
    wait_drained();

    // Longest Newton run, with no exit on convergence
    write_reg(CFG_ITER_LIMIT, 16'd255);
    write_reg(CFG_TOL, 16'd0);
    add_random(60);
    wait_drained();

    // Random settings
    repeat (4) begin
      write_reg(CFG_ITER_LIMIT, 16'($urandom_range(1, 255)));
      write_reg(CFG_TOL, 16'($urandom_range(0, 65535)));
      add_random(80);
      wait_drained();
    end

    $display("Checked %0d results over divide, multiply, power, root and bad opcodes,",
             results_seen);
    $display("across reset, extreme and random root settings with random stalls.");
    if (error_count == 0) begin
      $display("fixed_point_calculator_unit test passed");
    end else begin
      $display("%0d mismatches", error_count);
      $display("fixed_point_calculator_unit test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/fpcu_pkg.sv
design/fpcu_dp.sv
design/fpcu_ctrl.sv
design/fixed_point_calculator_unit.sv
design/fpcu_chk.sv
sim/tb_fixed_point_calculator_unit.sv
